### rtl/frl_pkg.sv
// Shared constants and types for the frame linear resampler.
package frl_pkg;

  localparam int SRC_LEN     = 2048;
  localparam int DEST_LEN    = 1024;
  localparam int FRAC_BITS   = 12;
  localparam int SAMPLE_W    = 16;
  localparam int RATIO_W     = 16;
  localparam int INDEX_W     = 11;
  localparam int OUT_INDEX_W = 10;

  localparam int SRC_AW      = $clog2(SRC_LEN);
  localparam int BANK_DEPTH  = SRC_LEN / 2;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int DEST_W      = $clog2(DEST_LEN);

  localparam int OFF_W       = DEST_W + RATIO_W + 1;
  localparam int PROD_W      = SAMPLE_W + 1 + FRAC_BITS + 1;

  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1 << FRAC_BITS);
  localparam logic signed [OFF_W-1:0] OFF_LIMIT =
    OFF_W'((SRC_LEN / 2) * (1 << FRAC_BITS));

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  typedef struct packed {
    logic                       en;
    logic [SRC_AW-1:0]          addr;
    logic signed [SAMPLE_W-1:0] data;
  } frl_wr_t;

  typedef struct packed {
    logic                   valid;
    logic                   in_range;
    logic [FRAC_BITS-1:0]   frac;
    logic [OUT_INDEX_W-1:0] idx;
  } frl_ctrl_t;

endpackage

### rtl/frl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/frl_store.sv
// Source frame store split into even and odd banks for a two-neighbor read.
module frl_store (
  input  logic                                 clk,
  input  frl_pkg::frl_wr_t                     wr,
  input  logic [frl_pkg::SRC_AW-1:0]           rd_lower,
  output logic signed [frl_pkg::SAMPLE_W-1:0]  a,
  output logic signed [frl_pkg::SAMPLE_W-1:0]  b
);

  logic [frl_pkg::SRC_AW:0]           upper;
  logic [frl_pkg::BANK_AW-1:0]        even_raddr;
  logic [frl_pkg::BANK_AW-1:0]        odd_raddr;
  logic [frl_pkg::SAMPLE_W-1:0]       even_q;
  logic [frl_pkg::SAMPLE_W-1:0]       odd_q;
  logic                               lower_odd;
  logic                               upper_past;

  assign upper      = {1'b0, rd_lower} + (frl_pkg::SRC_AW + 1)'(1);
  assign even_raddr = upper[frl_pkg::SRC_AW-1:1];
  assign odd_raddr  = rd_lower[frl_pkg::SRC_AW-1:1];

  frl_ram #(
    .WIDTH (frl_pkg::SAMPLE_W),
    .DEPTH (frl_pkg::BANK_DEPTH)
  ) u_even (
    .clk   (clk),
    .we    (wr.en && !wr.addr[0]),
    .waddr (wr.addr[frl_pkg::SRC_AW-1:1]),
    .wdata (wr.data),
    .raddr (even_raddr),
    .rdata (even_q)
  );

  frl_ram #(
    .WIDTH (frl_pkg::SAMPLE_W),
    .DEPTH (frl_pkg::BANK_DEPTH)
  ) u_odd (
    .clk   (clk),
    .we    (wr.en && wr.addr[0]),
    .waddr (wr.addr[frl_pkg::SRC_AW-1:1]),
    .wdata (wr.data),
    .raddr (odd_raddr),
    .rdata (odd_q)
  );

  always_ff @(posedge clk) begin
    lower_odd  <= rd_lower[0];
    upper_past <= upper[frl_pkg::SRC_AW];
  end

  always_comb begin
    a = lower_odd ? signed'(odd_q) : signed'(even_q);
    if (upper_past) begin
      b = '0;
    end else begin
      b = lower_odd ? signed'(even_q) : signed'(odd_q);
    end
  end

endmodule

### rtl/frl_blend.sv
// Weighted blend of the two neighbor samples and result register.
module frl_blend (
  input  logic                                 clk,
  input  logic                                 rst,
  input  frl_pkg::frl_ctrl_t                   ctrl,
  input  logic signed [frl_pkg::SAMPLE_W-1:0]  a,
  input  logic signed [frl_pkg::SAMPLE_W-1:0]  b,
  output logic                                 done,
  output logic [frl_pkg::OUT_INDEX_W-1:0]      out_index,
  output logic signed [frl_pkg::SAMPLE_W-1:0]  out_sample
);

  logic signed [frl_pkg::SAMPLE_W:0]             diff;
  logic signed [frl_pkg::FRAC_BITS:0]            weight;
  logic signed [frl_pkg::PROD_W-1:0]             prod;
  logic signed [frl_pkg::SAMPLE_W-1:0]           base;
  frl_pkg::frl_ctrl_t                            c_ctrl;
  logic signed [frl_pkg::PROD_W-frl_pkg::FRAC_BITS-1:0] step;
  logic signed [frl_pkg::PROD_W-frl_pkg::FRAC_BITS-1:0] sum;

  assign diff   = (frl_pkg::SAMPLE_W + 1)'(b) - (frl_pkg::SAMPLE_W + 1)'(a);
  assign weight = signed'({1'b0, ctrl.frac});

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctrl.valid <= 1'b0;
    end else begin
      c_ctrl.valid <= ctrl.valid;
    end
    c_ctrl.in_range <= ctrl.in_range;
    c_ctrl.frac     <= ctrl.frac;
    c_ctrl.idx      <= ctrl.idx;
    prod            <= frl_pkg::PROD_W'(diff * weight);
    base            <= a;
  end

  assign step = prod[frl_pkg::PROD_W-1:frl_pkg::FRAC_BITS];
  assign sum  = step + (frl_pkg::PROD_W - frl_pkg::FRAC_BITS)'(base);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_ctrl.valid;
    end
    out_index  <= c_ctrl.idx;
    out_sample <= c_ctrl.in_range ? sum[frl_pkg::SAMPLE_W-1:0] : '0;
  end

endmodule

### rtl/frame_linear_resampler.sv
// Top level of the frame linear resampler: offset stage, frame store and blend.
// Throughput: one request (load or compute) per cycle, busy never stalls.
// An accepted compute request with an index below 1024 passes through the offset
// multiply, store read, blend multiply and result register before it shows done.
// Loads are visible to any compute request accepted after them.
// Synchronous reset clears the pipeline valids and sets ratio to 1.0; frame
// contents are undefined until loaded.
module frame_linear_resampler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 mode,
  input  logic [frl_pkg::INDEX_W-1:0]          index,
  input  logic signed [frl_pkg::SAMPLE_W-1:0]  source_sample,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [frl_pkg::RATIO_W-1:0]          cfg_data,
  output logic                                 done,
  output logic [frl_pkg::OUT_INDEX_W-1:0]      out_index,
  output logic signed [frl_pkg::SAMPLE_W-1:0]  out_sample
);

  logic [frl_pkg::RATIO_W-1:0]        ratio;
  logic                               accept;
  logic signed [frl_pkg::DEST_W-1:0]  rel_idx;
  logic signed [frl_pkg::OFF_W-1:0]   off_prod;
  logic                               a_valid;
  logic signed [frl_pkg::OFF_W-1:0]   a_off;
  logic [frl_pkg::OUT_INDEX_W-1:0]    a_idx;
  logic [frl_pkg::OFF_W-1:0]          pos;
  frl_pkg::frl_wr_t                   wr;
  frl_pkg::frl_ctrl_t                 b_ctrl;
  logic signed [frl_pkg::SAMPLE_W-1:0] nb_a;
  logic signed [frl_pkg::SAMPLE_W-1:0] nb_b;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= frl_pkg::RATIO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ratio <= cfg_data;
    end
  end

  assign wr.en   = accept && (mode == frl_pkg::MODE_LOAD);
  assign wr.addr = index[frl_pkg::SRC_AW-1:0];
  assign wr.data = source_sample;

  assign rel_idx  = signed'({~index[frl_pkg::DEST_W-1], index[frl_pkg::DEST_W-2:0]});
  assign off_prod = frl_pkg::OFF_W'(rel_idx * signed'({1'b0, ratio}));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept && (mode == frl_pkg::MODE_COMPUTE) && !index[frl_pkg::DEST_W];
    end
    a_off <= off_prod;
    a_idx <= index[frl_pkg::OUT_INDEX_W-1:0];
  end

  assign pos = a_off + frl_pkg::OFF_LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctrl.valid <= 1'b0;
    end else begin
      b_ctrl.valid <= a_valid;
    end
    b_ctrl.in_range <= (a_off > -frl_pkg::OFF_LIMIT) && (a_off < frl_pkg::OFF_LIMIT);
    b_ctrl.frac     <= pos[frl_pkg::FRAC_BITS-1:0];
    b_ctrl.idx      <= a_idx;
  end

  frl_store u_store (
    .clk      (clk),
    .wr       (wr),
    .rd_lower (pos[frl_pkg::FRAC_BITS+frl_pkg::SRC_AW-1:frl_pkg::FRAC_BITS]),
    .a        (nb_a),
    .b        (nb_b)
  );

  frl_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (b_ctrl),
    .a          (nb_a),
    .b          (nb_b),
    .done       (done),
    .out_index  (out_index),
    .out_sample (out_sample)
  );

endmodule

### rtl/frl_checker.sv
// Port-level checker for the frame linear resampler, bound to the top level.
module frl_port_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 mode,
  input logic [frl_pkg::INDEX_W-1:0]          index,
  input logic                                 done,
  input logic [frl_pkg::OUT_INDEX_W-1:0]      out_index
);

  logic req;

  assign req = start && !busy && !rst && (mode == frl_pkg::MODE_COMPUTE) &&
               !index[frl_pkg::INDEX_W-1];

  a_req_done: assert property (@(posedge clk) disable iff (rst)
    req |-> ##4 done)
    else $error("compute request produced no result");

  a_done_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(req, 4))
    else $error("result without matching compute request");

  a_done_index: assert property (@(posedge clk) disable iff (rst)
    done |-> out_index == $past(index[frl_pkg::OUT_INDEX_W-1:0], 4))
    else $error("result index does not match request");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == frl_pkg::MODE_LOAD)) |-> ##4 !done)
    else $error("load request produced a result");

endmodule

bind frame_linear_resampler frl_port_checker u_frl_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .mode       (mode),
  .index      (index),
  .done       (done),
  .out_index  (out_index)
);
